// ----- hdl/apbe_pkg.sv -----
package apbe_pkg;

    // lengths up to 128 fit in one byte
    localparam int SPAN_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [31:0] pixel;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic [2:0]  out_bytes;
        logic        out_last;
    } word_t;

    typedef enum logic [1:0] {
        CMD_LIT_ADD,
        CMD_LIT_FLUSH,
        CMD_RUN,
        CMD_FINISH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [7:0]        data;
        logic [SPAN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_EVAL,
        F_RUN3,
        F_RUNCAP,
        F_CLOSE,
        F_LITCAP,
        F_LAST,
        F_FLUSHLIT,
        F_FINISH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RUN_HDR,
        B_RUN_VAL,
        B_LIT_HDR,
        B_LIT_DATA,
        B_FINISH
    } back_state_t;

endpackage

// ----- hdl/apbe_ram.sv -----
module apbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/apbe_queue.sv -----
module apbe_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  apbe_pkg::cmd_t         push_data,
    input  logic                   pop,
    output apbe_pkg::cmd_t         pop_data,
    output apbe_pkg::queue_status_t status
);

    import apbe_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    always_comb
    begin
        do_push     = push && !status.full;
        do_pop      = pop && !status.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ----- hdl/apbe_front.sv -----
module apbe_front #(
    parameter int MAX_SPAN = 128
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pixel_valid,
    output logic                    pixel_stall,
    input  apbe_pkg::pixel_t        pixel_data,
    output logic                    cmd_push,
    output apbe_pkg::cmd_t          cmd_data,
    input  apbe_pkg::queue_status_t q_status
);

    import apbe_pkg::*;

    localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(MAX_SPAN);
    localparam logic [SPAN_W-1:0] RUN_MIN  = SPAN_W'(3);

    front_state_t      state_reg, state_next;
    logic [7:0]        alpha_reg, alpha_next;
    logic              last_reg, last_next;
    logic              phase_reg, phase_next;
    logic [7:0]        run_byte_reg, run_byte_next;
    logic [SPAN_W-1:0] run_len_reg, run_len_next;
    logic [SPAN_W-1:0] lit_len_reg, lit_len_next;
    logic              want;
    logic              can_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            phase_reg    <= 1'b0;
            last_reg     <= 1'b0;
            run_byte_reg <= '0;
            run_len_reg  <= '0;
            lit_len_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            last_reg     <= last_next;
            run_byte_reg <= run_byte_next;
            run_len_reg  <= run_len_next;
            lit_len_reg  <= lit_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= alpha_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        alpha_next    = alpha_reg;
        last_next     = last_reg;
        phase_next    = phase_reg;
        run_byte_next = run_byte_reg;
        run_len_next  = run_len_reg;
        lit_len_next  = lit_len_reg;
        want          = 1'b0;
        can_push      = !q_status.full;
        cmd_data      = '{op: CMD_LIT_ADD, data: run_byte_reg, len: run_len_reg};

        case (state_reg)
            F_IDLE:
            begin
                if (pixel_valid)
                begin
                    alpha_next = pixel_data.pixel[31:24];
                    last_next  = pixel_data.last_pixel;
                    phase_next = 1'b0;
                    state_next = F_EVAL;
                end
            end
            F_EVAL:
            begin
                if (run_len_reg != '0 && alpha_reg == run_byte_reg)
                begin
                    run_len_next = run_len_reg + 1'b1;
                    state_next   = F_RUN3;
                end
                else
                begin
                    state_next = F_CLOSE;
                end
            end
            F_RUN3:
            begin
                // a run of three ends the pending literal
                if (run_len_reg == RUN_MIN && lit_len_reg != '0)
                begin
                    want        = 1'b1;
                    cmd_data.op = CMD_LIT_FLUSH;
                    if (can_push)
                    begin
                        lit_len_next = '0;
                        state_next   = F_RUNCAP;
                    end
                end
                else
                begin
                    state_next = F_RUNCAP;
                end
            end
            F_RUNCAP:
            begin
                if (run_len_reg >= SPAN_MAX)
                begin
                    want        = 1'b1;
                    cmd_data.op = CMD_RUN;
                    if (can_push)
                    begin
                        run_len_next = '0;
                        state_next   = F_LAST;
                    end
                end
                else
                begin
                    state_next = F_LAST;
                end
            end
            F_CLOSE:
            begin
                if (run_len_reg >= RUN_MIN)
                begin
                    want        = 1'b1;
                    cmd_data.op = CMD_RUN;
                    if (can_push)
                    begin
                        run_len_next = '0;
                    end
                end
                else if (run_len_reg != '0)
                begin
                    // short group goes into the literal one byte at a time
                    want        = 1'b1;
                    cmd_data.op = CMD_LIT_ADD;
                    if (can_push)
                    begin
                        run_len_next = run_len_reg - 1'b1;
                        lit_len_next = lit_len_reg + 1'b1;
                        if (lit_len_next == SPAN_MAX)
                        begin
                            state_next = F_LITCAP;
                        end
                    end
                end
                else if (!phase_reg)
                begin
                    run_byte_next = alpha_reg;
                    run_len_next  = SPAN_W'(1);
                    state_next    = F_LAST;
                end
                else
                begin
                    state_next = F_FLUSHLIT;
                end
            end
            F_LITCAP:
            begin
                want        = 1'b1;
                cmd_data.op = CMD_LIT_FLUSH;
                if (can_push)
                begin
                    lit_len_next = '0;
                    state_next   = F_CLOSE;
                end
            end
            F_LAST:
            begin
                if (last_reg)
                begin
                    phase_next = 1'b1;
                    state_next = F_CLOSE;
                end
                else
                begin
                    state_next = F_IDLE;
                end
            end
            F_FLUSHLIT:
            begin
                if (lit_len_reg != '0)
                begin
                    want        = 1'b1;
                    cmd_data.op = CMD_LIT_FLUSH;
                    if (can_push)
                    begin
                        lit_len_next = '0;
                        state_next   = F_FINISH;
                    end
                end
                else
                begin
                    state_next = F_FINISH;
                end
            end
            F_FINISH:
            begin
                want        = 1'b1;
                cmd_data.op = CMD_FINISH;
                if (can_push)
                begin
                    run_byte_next = '0;
                    run_len_next  = '0;
                    lit_len_next  = '0;
                    phase_next    = 1'b0;
                    state_next    = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign cmd_push    = want && can_push;
    assign pixel_stall = (state_reg != F_IDLE);

endmodule

// ----- hdl/apbe_back.sv -----
module apbe_back #(
    parameter int MAX_SPAN = 128
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  apbe_pkg::cmd_t          cmd_data,
    input  apbe_pkg::queue_status_t q_status,
    output logic                    cmd_pop,
    output logic                    word_valid,
    input  logic                    word_stall,
    output apbe_pkg::word_t         word_data
);

    import apbe_pkg::*;

    localparam int                ADDR_W   = $clog2(MAX_SPAN);
    localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(MAX_SPAN);

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [SPAN_W-1:0] lit_cnt_reg, lit_cnt_next;
    logic [SPAN_W-1:0] idx_reg, idx_next;
    logic [31:0]       word_reg, word_next;
    logic [2:0]        fill_reg, fill_next;
    logic              out_valid_reg, out_valid_next;
    word_t             out_data_reg, out_data_next;

    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              put_req;
    logic [7:0]        put_val;
    logic              put_ok;
    logic              slot_free;
    logic              send_full;
    logic              send_last;

    apbe_ram #(
        .WIDTH(8),
        .DEPTH(MAX_SPAN)
    ) u_lit_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (lit_cnt_reg[ADDR_W-1:0]),
        .wr_data (cmd_data.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            lit_cnt_reg   <= '0;
            word_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lit_cnt_reg   <= lit_cnt_next;
            word_reg      <= word_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lit_cnt_next   = lit_cnt_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        put_req        = 1'b0;
        put_val        = '0;
        send_full      = 1'b0;
        send_last      = 1'b0;

        slot_free = !out_valid_reg || !word_stall;
        // a full word waits for the next byte or the frame end
        put_ok    = (fill_reg != 3'd4) || slot_free;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_data.op)
                        CMD_LIT_ADD:
                        begin
                            wr_en        = 1'b1;
                            lit_cnt_next = lit_cnt_reg + 1'b1;
                        end
                        CMD_RUN:
                        begin
                            cmd_next   = cmd_data;
                            state_next = B_RUN_HDR;
                        end
                        CMD_LIT_FLUSH:
                        begin
                            state_next = B_LIT_HDR;
                        end
                        CMD_FINISH:
                        begin
                            state_next = B_FINISH;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_RUN_HDR:
            begin
                put_req = 1'b1;
                put_val = 8'(9'd257 - 9'(cmd_reg.len));
                if (put_ok)
                begin
                    state_next = B_RUN_VAL;
                end
            end
            B_RUN_VAL:
            begin
                put_req = 1'b1;
                put_val = cmd_reg.data;
                if (put_ok)
                begin
                    state_next = B_IDLE;
                end
            end
            B_LIT_HDR:
            begin
                put_req = 1'b1;
                put_val = 8'(lit_cnt_reg - SPAN_W'(1));
                if (put_ok)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = SPAN_W'(1);
                    state_next = B_LIT_DATA;
                end
            end
            B_LIT_DATA:
            begin
                // rd_data holds byte idx-1; the next read goes out as it is taken
                put_req = 1'b1;
                put_val = rd_data;
                if (put_ok)
                begin
                    if (idx_reg == lit_cnt_reg)
                    begin
                        lit_cnt_next = '0;
                        state_next   = B_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg[ADDR_W-1:0];
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            B_FINISH:
            begin
                if (fill_reg == '0)
                begin
                    word_next  = '0;
                    state_next = B_IDLE;
                end
                else if (slot_free)
                begin
                    send_last  = 1'b1;
                    word_next  = '0;
                    fill_next  = '0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (put_req && put_ok)
        begin
            if (fill_reg == 3'd4)
            begin
                send_full = 1'b1;
                word_next = {24'b0, put_val};
                fill_next = 3'd1;
            end
            else
            begin
                word_next = word_reg | ({24'b0, put_val} << {fill_reg[1:0], 3'b000});
                fill_next = fill_reg + 1'b1;
            end
        end

        if (send_full)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '{out_word: word_reg, out_bytes: 3'd4, out_last: 1'b0};
        end
        else if (send_last)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '{out_word: word_reg, out_bytes: fill_reg, out_last: 1'b1};
        end
        else if (!word_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign word_valid = out_valid_reg;
    assign word_data  = out_data_reg;

    a_lit_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        lit_cnt_reg <= SPAN_MAX)
        else $error("literal count beyond span");

    a_lit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LIT_DATA) |-> (idx_reg != '0 && idx_reg <= lit_cnt_reg))
        else $error("literal read index out of range");

    a_out_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.out_bytes != 3'd0 && out_data_reg.out_bytes <= 3'd4))
        else $error("word byte count out of range");

endmodule

// ----- hdl/alpha_packbits_encoder.sv -----
// PackBits encoder for the alpha plane of a BGRA pixel stream. Each pixel item carries a
// 32-bit pixel whose top byte is encoded; last_pixel closes the frame, flushes all pending
// data and marks the final word with out_last, after which the encoder starts a fresh
// frame. Runs of 3 to MAX_SPAN equal bytes become a header (257 - length) and the value,
// other bytes gather into literals of up to MAX_SPAN bytes. Encoded bytes leave packed
// up to four to a word, first byte in bits 7:0, unused high bytes zero. The classifier
// stalls the pixel input from the accepting edge until its step sequencer is idle again.
// Closing a group queues a command for a run, for each literal byte and for a literal
// flush at the cap, and the frame end queues the commands that close the final group.
// A full four-entry command queue stalls the classifier further. The emitter behind the
// queue pops each command and then sends one encoded byte per cycle while the word output
// is not stalled: two for a run, and for a literal flush one for the header and one per
// stored byte from the literal RAM read port. A full word is released only when the next
// byte arrives or the frame ends. The literal store needs no clearing after reset.
module alpha_packbits_encoder #(
    parameter int MAX_SPAN = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  apbe_pkg::pixel_t  pixel_data,
    output logic              word_valid,
    input  logic              word_stall,
    output apbe_pkg::word_t   word_data
);

    import apbe_pkg::*;

    logic          cmd_push;
    cmd_t          cmd_in;
    logic          cmd_pop;
    cmd_t          cmd_out;
    queue_status_t q_status;

    apbe_front #(
        .MAX_SPAN(MAX_SPAN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_data  (pixel_data),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_in),
        .q_status    (q_status)
    );

    apbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .status    (q_status)
    );

    apbe_back #(
        .MAX_SPAN(MAX_SPAN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_data   (cmd_out),
        .q_status   (q_status),
        .cmd_pop    (cmd_pop),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_data  (word_data)
    );

endmodule

// ----- tb/sv/apbe_word_checker.sv -----
`timescale 1ns / 1ps

module apbe_word_checker #(
    parameter int MAX_SPAN = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    input  logic             pixel_stall,
    input  apbe_pkg::pixel_t pixel_data,
    input  logic             word_valid,
    input  logic             word_stall,
    input  apbe_pkg::word_t  word_data,
    output int               mismatches,
    output int               pending
);

    import apbe_pkg::*;

    logic [7:0]  lit_bytes [MAX_SPAN];
    int          lit_count = 0;
    logic [7:0]  grp_byte  = '0;
    int          grp_len   = 0;
    logic [31:0] acc_word  = '0;
    int          acc_fill  = 0;
    word_t       expected_words [$];

    function automatic void clear_encoder();
        lit_count = 0;
        grp_byte  = '0;
        grp_len   = 0;
        acc_word  = '0;
        acc_fill  = 0;
    endfunction

    function automatic void queue_word(logic [31:0] w, int n, logic fin);
        word_t entry;
        entry.out_word  = w;
        entry.out_bytes = 3'(n);
        entry.out_last  = fin;
        expected_words.push_back(entry);
    endfunction

    // a full word only leaves once the next byte shows up
    function automatic void put_byte(logic [7:0] b);
        if (acc_fill >= 4)
        begin
            queue_word(acc_word, 4, 1'b0);
            acc_word = '0;
            acc_fill = 0;
        end
        acc_word |= 32'(b) << (8 * acc_fill);
        acc_fill++;
    endfunction

    function automatic void flush_literal();
        if (lit_count == 0)
            return;
        put_byte(8'(lit_count - 1));
        for (int i = 0; i < lit_count; i++)
            put_byte(lit_bytes[i]);
        lit_count = 0;
    endfunction

    function automatic void add_literal(logic [7:0] b);
        if (lit_count < MAX_SPAN)
        begin
            lit_bytes[lit_count] = b;
            lit_count++;
        end
        if (lit_count >= MAX_SPAN)
            flush_literal();
    endfunction

    function automatic void emit_run();
        put_byte(8'(257 - grp_len));
        put_byte(grp_byte);
        grp_len = 0;
    endfunction

    // groups shorter than three fall back into the literal
    function automatic void close_group();
        if (grp_len >= 3)
        begin
            emit_run();
        end
        else
        begin
            for (int i = 0; i < grp_len; i++)
                add_literal(grp_byte);
            grp_len = 0;
        end
    endfunction

    function automatic void encode_alpha(pixel_t item);
        logic [7:0] alpha;
        alpha = item.pixel[31:24];
        if (grp_len > 0 && alpha == grp_byte)
        begin
            grp_len++;
            if (grp_len == 3)
                flush_literal();
            if (grp_len >= MAX_SPAN)
                emit_run();
        end
        else
        begin
            close_group();
            grp_byte = alpha;
            grp_len  = 1;
        end
        if (item.last_pixel)
        begin
            close_group();
            flush_literal();
            if (acc_fill > 0)
                queue_word(acc_word, acc_fill, 1'b1);
            clear_encoder();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_word(input word_t got);
        word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h", got.out_word));
            return;
        end
        want = expected_words.pop_front();
        if (got.out_word !== want.out_word)
            report_mismatch($sformatf("out_word %h, predicted %h",
                                      got.out_word, want.out_word));
        if (got.out_bytes !== want.out_bytes)
            report_mismatch($sformatf("out_bytes %0d, predicted %0d",
                                      got.out_bytes, want.out_bytes));
        if (got.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %b, predicted %b",
                                      got.out_last, want.out_last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_encoder();
            expected_words.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (word_valid && !word_stall)
                check_word(word_data);
            if (pixel_valid && !pixel_stall)
                encode_alpha(pixel_data);
            pending = expected_words.size();
        end
    end

endmodule

// ----- tb/sv/tb_alpha_packbits_encoder.sv -----
`timescale 1ns / 1ps

module tb_alpha_packbits_encoder;
    import apbe_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 200;
    localparam int SHORT_ITEMS  = 16;

    logic   clk   = 1'b0;
    logic   rst_n = 1'b0;
    logic   pixel_valid;
    logic   pixel_stall;
    pixel_t pixel_data;
    logic   word_valid;
    logic   word_stall;
    word_t  word_data;

    int     mismatches;
    int     pending;
    int     pixels_sent = 0;
    int     words_taken = 0;
    int     quiet_cycles = 0;
    logic   hold_start = 1'b0;
    logic   hold_done  = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    alpha_packbits_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_data  (pixel_data),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word_data   (word_data)
    );

    apbe_word_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_data  (pixel_data),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word_data   (word_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    function automatic logic [7:0] other_than(logic [7:0] v);
        return v + 8'(1 + $urandom_range(254));
    endfunction

    task automatic send_pixel(input logic [7:0] alpha, input logic fin);
        pixel_t item;
        item.pixel      = {alpha, 24'($urandom)};
        item.last_pixel = fin;
        // no gaps at all for a stretch of items
        while (!(pixels_sent > 60 && pixels_sent < 130) && $urandom_range(99) < 14)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_data  <= item;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic send_short_frame(output int len);
        logic [7:0] palette [4];
        logic [7:0] alpha;
        int         mode;
        len  = $urandom_range(1, 24);
        mode = $urandom_range(2);
        foreach (palette[k])
            palette[k] = 8'($urandom);
        alpha = palette[0];
        for (int k = 0; k < len; k++)
        begin
            case (mode)
                0: alpha = 8'($urandom);
                1: if ($urandom_range(1)) alpha = palette[$urandom_range(3)];
                default: if ($urandom_range(3) == 0) alpha = other_than(alpha);
            endcase
            send_pixel(alpha, k == len - 1);
        end
    endtask

    // 127 literal bytes, then a pair that only half fits
    task automatic send_literal_cap_frame();
        logic [7:0] alpha;
        logic [7:0] pair;
        alpha = 8'($urandom);
        for (int k = 0; k < 127; k++)
        begin
            alpha = other_than(alpha);
            send_pixel(alpha, 1'b0);
        end
        pair = other_than(alpha);
        send_pixel(pair, 1'b0);
        send_pixel(pair, 1'b0);
        alpha = other_than(pair);
        send_pixel(alpha, 1'b0);
        send_pixel(other_than(alpha), 1'b1);
    endtask

    // a run past its cap restarts as a new group
    task automatic send_run_cap_frame();
        logic [7:0] alpha;
        alpha = 8'($urandom);
        for (int k = 0; k < 130; k++)
            send_pixel(alpha, 1'b0);
        send_pixel(other_than(alpha), 1'b1);
    endtask

    initial
    begin
        word_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (word_valid && !word_stall)
                words_taken++;
            if (hold_start && !hold_done)
            begin
                word_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                word_stall <= (words_taken < 20 || words_taken > 70)
                              && $urandom_range(99) < 14;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (word_valid && !word_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no handshake for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int len;
        int short_total;
        pixel_valid = 1'b0;
        pixel_data  = '0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone pixel, extremes of alpha
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b1);
        // pair inside a literal, then a run, then a literal tail
        send_pixel(8'h12, 1'b0);
        send_pixel(8'h12, 1'b0);
        send_pixel(8'h34, 1'b0);
        send_pixel(8'h56, 1'b0);
        send_pixel(8'h56, 1'b0);
        send_pixel(8'h56, 1'b0);
        send_pixel(8'h56, 1'b0);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h7F, 1'b1);
        // exactly one full word held to the end of the frame
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h02, 1'b0);
        send_pixel(8'h03, 1'b1);
        // five bytes: full word released by the next byte
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b1);
        // run closed by a new byte in the last pixel of the frame
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b1);

        hold_start = 1'b1;
        short_total = 0;
        while (short_total < SHORT_ITEMS)
        begin
            send_short_frame(len);
            short_total += len;
        end
        send_literal_cap_frame();
        send_run_cap_frame();
        short_total = 0;
        while (short_total < SHORT_ITEMS / 2)
        begin
            send_short_frame(len);
            short_total += len;
        end
        pixel_valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            if (pending != 0)
                $display("%0d predicted words never arrived", pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
